@@ rtl/core/ids_pkg.sv @@
// shared types and constants of the indentation token scanner
`default_nettype none

package ids_pkg;

  localparam logic [1:0] TOK_INDENT  = 2'd0;
  localparam logic [1:0] TOK_DEDENT  = 2'd1;
  localparam logic [1:0] TOK_NEWLINE = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [7:0] COUNT_MAX = 8'hff;

  typedef enum logic [2:0] {
    MODE_BODY    = 3'b001,
    MODE_MEASURE = 3'b010,
    MODE_COMMENT = 3'b100
  } mode_t;

  // one decided line or end of input, handed from front to back
  typedef struct packed {
    logic       is_end;
    logic [7:0] cnt;
    logic       ok_ind;
    logic       ok_ded;
    logic       ok_nl;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/ids_front.sv @@
// front end: line mode tracking, blank counting and line classification
`default_nettype none

module ids_front import ids_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       at_end,
  input  wire logic       allow_indent,
  input  wire logic       allow_dedent,
  input  wire logic       allow_newline,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            cmd
);

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] count;
  logic [7:0] count_next;
  logic       is_blank;
  logic       is_special;
  logic       decides;
  logic       accept;

  assign is_blank   = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_special = is_blank || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_HASH);
  assign decides    = at_end || ((mode == MODE_MEASURE) && !is_special);
  assign in_stall   = decides && q_full;
  assign accept     = in_valid && !in_stall;
  assign push       = accept && decides;

  assign cmd.is_end = at_end;
  assign cmd.cnt    = count;
  assign cmd.ok_ind = allow_indent;
  assign cmd.ok_ded = allow_dedent;
  assign cmd.ok_nl  = allow_newline;

  always_comb begin
    mode_next  = mode;
    count_next = count;
    if (at_end) begin
      mode_next  = MODE_BODY;
      count_next = '0;
    end else begin
      unique case (mode)
        MODE_MEASURE: begin
          if (is_blank) begin
            if (count != COUNT_MAX) count_next = count + 8'd1;
          end else if (ch == CH_LF) begin
            count_next = '0;
          end else if (ch == CH_CR) begin
            count_next = count;
          end else if (ch == CH_HASH) begin
            mode_next = MODE_COMMENT;
          end else begin
            mode_next  = MODE_BODY;
            count_next = '0;
          end
        end
        MODE_COMMENT: begin
          if (ch == CH_LF) begin
            mode_next  = MODE_MEASURE;
            count_next = '0;
          end
        end
        MODE_BODY: begin
          if (ch == CH_LF) begin
            mode_next  = MODE_MEASURE;
            count_next = '0;
          end
        end
        default: begin
          mode_next  = MODE_BODY;
          count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_BODY;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ids_queue.sv @@
// two-entry command queue between front and back
`default_nettype none

module ids_queue import ids_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic pop
);

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);

  cmd_t             slots [QD];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     fill;

  assign full    = (fill == (QAW+1)'(QD));
  assign q_valid = (fill != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QAW+1)'(1);
        2'b01:   fill <= fill - (QAW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ids_back.sv @@
// back end: indentation stack, dedent sequencing and token output register
`default_nettype none

module ids_back import ids_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      token,
  output logic [4:0]      level,
  output logic            last
);

  localparam int DW = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMD  = 5'b00010,
    S_POP  = 5'b00100,
    S_WAIT = 5'b01000,
    S_NL   = 5'b10000
  } state_t;

  state_t         state;
  state_t         state_next;
  cmd_t           cmd;
  logic [7:0]     mem [STACK_DEPTH];
  logic [7:0]     rd_data;
  logic [7:0]     top;
  logic [7:0]     target;
  logic [DW-1:0]  depth;
  logic [DW-1:0]  depth_up;
  logic [DW-1:0]  depth_dn;
  logic [DW-1:0]  rd_addr;
  logic           at_top;
  logic           pop_now;
  logic           more;
  logic           out_free;
  logic           emit;
  logic [1:0]     emit_tok;
  logic [DW-1:0]  emit_level;
  logic           emit_last;
  logic           push_en;
  logic           pop_en;

  assign depth_up = depth + DW'(1);
  assign depth_dn = depth - DW'(1);
  assign rd_addr  = (depth == '0) ? '0 : depth_dn;
  assign at_top   = (depth == DW'(STACK_DEPTH - 1));
  assign pop_now  = (depth != '0) && (top > target);
  // entry below the top, from the registered stack read; valid once that read has caught up with depth
  assign more     = (depth != DW'(1)) && (rd_data > target);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_tok   = TOK_NEWLINE;
    emit_level = depth;
    emit_last  = 1'b1;
    push_en    = 1'b0;
    pop_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) state_next = S_CMD;
      end
      S_CMD: begin
        if (cmd.is_end) begin
          if (cmd.ok_ded)     state_next = S_POP;
          else if (cmd.ok_nl) state_next = S_NL;
          else                state_next = S_IDLE;
        end else if ((cmd.cnt > top) && cmd.ok_ind) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_tok   = TOK_INDENT;
            emit_level = at_top ? depth : depth_up;
            push_en    = !at_top;
            state_next = S_IDLE;
          end
        end else if ((cmd.cnt < top) && cmd.ok_ded) begin
          state_next = S_POP;
        end else if (cmd.ok_nl) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (pop_now) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_tok   = TOK_DEDENT;
            emit_level = depth_dn;
            emit_last  = !more && !(cmd.is_end && cmd.ok_nl);
            pop_en     = 1'b1;
            state_next = S_WAIT;
          end
        end else if (cmd.is_end && cmd.ok_nl) begin
          state_next = S_NL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        state_next = S_POP;
      end
      S_NL: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (push_en) mem[depth_up] <= cmd.cnt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (state == S_CMD) target <= cmd.is_end ? 8'd0 : cmd.cnt;
    if (emit) begin
      token <= emit_tok;
      level <= 5'(emit_level);
      last  <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push_en) begin
        depth <= depth_up;
        top   <= cmd.cnt;
      end else if (pop_en) begin
        depth <= depth_dn;
        top   <= (depth == DW'(1)) ? 8'd0 : rd_data;
      end
      if (emit)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/indent_dedent_token_scanner.sv @@
// top level of the indentation token scanner
//
// Input channel: one source character per item (ch), or an end-of-input
// mark (at_end), with the parser's token-allowed flags. Output channel:
// one token per item (token, level, last); last marks the final token
// caused by one input item. Both channels use valid/stall.
// A character that queues no command is taken every cycle. The first real
// character after a line feed, and end of input, queue a command in a
// two-entry queue; the input stalls only while that queue is full.
// The back end takes a new command from the queue only while idle. An
// INDENT or NEWLINE is registered straight from the command state; a
// command that pops goes to a pop state that registers one DEDENT per
// pop and then passes a wait state for the stack memory's registered
// read of the entry below the top; after end of input a NEWLINE state
// may follow.
// A stalled output holds its token; the back end waits and the queue
// fills, then the input stalls.
// Reset (synchronous, active high) empties the queue and the stack,
// drops any pending token and returns to line-body mode; the stack
// memory needs no clearing pass.
`default_nettype none

module indent_dedent_token_scanner import ids_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       at_end,
  input  wire logic       allow_indent,
  input  wire logic       allow_dedent,
  input  wire logic       allow_newline,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      token,
  output logic [4:0]      level,
  output logic            last
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  ids_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .at_end        (at_end),
    .allow_indent  (allow_indent),
    .allow_dedent  (allow_dedent),
    .allow_newline (allow_newline),
    .q_full        (q_full),
    .push          (front_push),
    .cmd           (front_cmd)
  );

  ids_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  ids_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .token     (token),
    .level     (level),
    .last      (last)
  );

endmodule

`default_nettype wire

@@ rtl/core/ids_checker.sv @@
// port-level assertions for the indentation token scanner, with bind
`default_nettype none

module ids_checker import ids_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] token,
  input wire logic [4:0] level,
  input wire logic       last
);

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token) && $stable(level) && $stable(last))
    else $error("output token changed while stalled");

  // indent and newline always close the burst of their item
  a_indent_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token == TOK_INDENT) |-> last)
    else $error("indent token not marked last");

  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token == TOK_NEWLINE) |-> last)
    else $error("newline token not marked last");

  // nothing pending straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind indent_dedent_token_scanner ids_checker u_ids_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .token     (token),
  .level     (level),
  .last      (last)
);

`default_nettype wire
